/* rtl/octant_atan2_table_angle_core_assert.svh */
// Assertion macros shared by the checker of the octant arctangent core.
// Needs clk and rst_n to be visible where a macro is used.
`ifndef OCTANT_ATAN2_TABLE_ANGLE_CORE_ASSERT_SVH
`define OCTANT_ATAN2_TABLE_ANGLE_CORE_ASSERT_SVH

// Property checked outside reset.
`define OATA_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("octant atan2 core check failed");

// Property checked at every edge, reset included.
`define OATA_CHK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("octant atan2 core reset check failed");

`endif

/* rtl/oata_pkg.sv */
// Shared constants and types of the octant arctangent core.
// No dependencies.
package oata_pkg;

  localparam int RATIO_SCALE = 640;
  localparam int TABLE_DEPTH = RATIO_SCALE + 1;
  localparam int Q_BITS      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = 10;
  localparam int CRD_W       = 32;
  localparam int ANG_W       = 16;

  localparam logic [ANG_W-1:0] ANG_Q0 = 16'h0000;
  localparam logic [ANG_W-1:0] ANG_Q1 = 16'h0400;
  localparam logic [ANG_W-1:0] ANG_Q2 = 16'h0800;
  localparam logic [ANG_W-1:0] ANG_Q3 = 16'h0C00;
  localparam logic [ANG_W-1:0] ANG_Q4 = 16'h1000;

  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  // What travels with an item down the pipeline.
  typedef struct packed {
    logic             vld;
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic [ANG_W-1:0] val;
    logic             zero;
    logic             sub;
    logic [ANG_W-1:0] base;
  } meta_t;

endpackage

/* rtl/oata_cell.sv */
// One restoring division cell: produces one quotient bit per item.
// Depends on oata_pkg.
module oata_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  oata_pkg::meta_t              meta_i,
  input  logic [oata_pkg::CRD_W-1:0]   rem_i,
  input  logic [oata_pkg::CRD_W-1:0]   div_i,
  input  logic [oata_pkg::Q_BITS-1:0]  nb_i,
  input  logic [oata_pkg::Q_BITS-1:0]  quo_i,
  output oata_pkg::meta_t              meta_o,
  output logic [oata_pkg::CRD_W-1:0]   rem_o,
  output logic [oata_pkg::CRD_W-1:0]   div_o,
  output logic [oata_pkg::Q_BITS-1:0]  nb_o,
  output logic [oata_pkg::Q_BITS-1:0]  quo_o
);
  import oata_pkg::*;

  meta_t             meta_r;
  logic [CRD_W-1:0]  rem_r, rem_nxt, div_r;
  logic [Q_BITS-1:0] nb_r, quo_r;
  logic [CRD_W:0]    wide, diff;
  logic              ge;

  // The partial remainder stays below the divisor, so one bit more suffices.
  always_comb begin
    wide    = {rem_i, nb_i[Q_BITS-1]};
    diff    = wide - {1'b0, div_i};
    ge      = wide >= {1'b0, div_i};
    rem_nxt = ge ? diff[CRD_W-1:0] : wide[CRD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.vld <= 1'b0;
    end else if (en) begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= div_i;
      nb_r  <= {nb_i[Q_BITS-2:0], 1'b0};
      quo_r <= {quo_i[Q_BITS-2:0], ge};
    end
  end

  assign meta_o = meta_r;
  assign rem_o  = rem_r;
  assign div_o  = div_r;
  assign nb_o   = nb_r;
  assign quo_o  = quo_r;

endmodule

/* rtl/octant_atan2_table_angle_core.sv */
// Octant arctangent core: an item either writes one of 641 table entries or
// asks for the negated heading of a vector, 0x1000 steps per turn. One item
// is taken every cycle unless the output stalls; a heading is set by
// two front stages, a prescale stage, a chain of ten divider cells (one
// quotient bit each), the table read and the output register. Writes travel
// the same pipeline, so every item sees the table as earlier items left it.
// The whole pipeline holds while a result waits to be taken.
module octant_atan2_table_angle_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [oata_pkg::CRD_W-1:0]   in_from_x,
  input  logic signed [oata_pkg::CRD_W-1:0]   in_from_z,
  input  logic signed [oata_pkg::CRD_W-1:0]   in_to_x,
  input  logic signed [oata_pkg::CRD_W-1:0]   in_to_z,
  input  logic [oata_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [oata_pkg::ANG_W-1:0]   in_entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [oata_pkg::ANG_W-1:0]   out_heading
);
  import oata_pkg::*;

  localparam int N_W = CRD_W + Q_BITS;

  logic adv;

  // Stage 1: deltas.
  meta_t            m1_r;
  logic [CRD_W-1:0] dx1_r, w1_r;

  // Stage 2: magnitudes and octant.
  meta_t            m2_r, m2_nxt;
  logic [CRD_W-1:0] s2_r, l2_r, s2_nxt, l2_nxt, ax, aw;
  logic             xn, wn, lt_xw, lt_wx;

  // Stage 3: scaled numerator split into remainder and bits to bring down.
  meta_t             m3_r;
  logic [CRD_W-1:0]  rem3_r, l3_r;
  logic [Q_BITS-1:0] nb3_r;
  logic [N_W-1:0]    num;

  meta_t             c_meta [Q_BITS+1];
  logic [CRD_W-1:0]  c_rem  [Q_BITS+1];
  logic [CRD_W-1:0]  c_div  [Q_BITS+1];
  logic [Q_BITS-1:0] c_nb   [Q_BITS+1];
  logic [Q_BITS-1:0] c_quo  [Q_BITS+1];

  // Stage 4: table.
  logic [ANG_W-1:0] arctan_mem [TABLE_DEPTH];
  logic [ANG_W-1:0] t4_r;
  meta_t            m4_r;

  logic [ANG_W-1:0] angle;
  logic [ANG_W-1:0] heading_r;
  logic             out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r.vld <= 1'b0;
    end else if (adv) begin
      m1_r.vld <= in_valid;
    end
    if (adv) begin
      m1_r.cmd  <= in_command;
      m1_r.idx  <= in_entry_index;
      m1_r.val  <= in_entry_value;
      m1_r.zero <= 1'b0;
      m1_r.sub  <= 1'b0;
      m1_r.base <= ANG_Q0;
      dx1_r     <= in_to_x - in_from_x;
      w1_r      <= in_from_z - in_to_z;
    end
  end

  always_comb begin
    xn    = dx1_r[CRD_W-1];
    wn    = w1_r[CRD_W-1];
    ax    = xn ? (-dx1_r) : dx1_r;
    aw    = wn ? (-w1_r) : w1_r;
    lt_xw = ax < aw;
    lt_wx = aw < ax;
    s2_nxt = lt_xw ? ax : aw;
    l2_nxt = lt_xw ? aw : ax;
    m2_nxt      = m1_r;
    m2_nxt.zero = (dx1_r == '0) && (w1_r == '0);
    case ({xn, wn})
      2'b00: begin
        m2_nxt.sub  = !lt_xw;
        m2_nxt.base = lt_xw ? ANG_Q0 : ANG_Q1;
      end
      2'b01: begin
        m2_nxt.sub  = !lt_wx;
        m2_nxt.base = lt_wx ? ANG_Q1 : ANG_Q2;
      end
      2'b11: begin
        m2_nxt.sub  = !lt_xw;
        m2_nxt.base = lt_xw ? ANG_Q2 : ANG_Q3;
      end
      2'b10: begin
        m2_nxt.sub  = !lt_wx;
        m2_nxt.base = lt_wx ? ANG_Q3 : ANG_Q4;
      end
      default: begin
        m2_nxt.sub  = 1'b0;
        m2_nxt.base = ANG_Q0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r.vld <= 1'b0;
    end else if (adv) begin
      m2_r <= m2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
      l2_r <= l2_nxt;
    end
  end

  // Since small never exceeds large, the top word of the numerator is
  // already below the divisor and only the low bits need cells.
  assign num = N_W'(s2_r) * N_W'(RATIO_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_r.vld <= 1'b0;
    end else if (adv) begin
      m3_r <= m2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem3_r <= num[N_W-1:Q_BITS];
      nb3_r  <= num[Q_BITS-1:0];
      l3_r   <= l2_r;
    end
  end

  assign c_meta[0] = m3_r;
  assign c_rem[0]  = rem3_r;
  assign c_div[0]  = l3_r;
  assign c_nb[0]   = nb3_r;
  assign c_quo[0]  = '0;

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    oata_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .meta_i (c_meta[i]),
      .rem_i  (c_rem[i]),
      .div_i  (c_div[i]),
      .nb_i   (c_nb[i]),
      .quo_i  (c_quo[i]),
      .meta_o (c_meta[i+1]),
      .rem_o  (c_rem[i+1]),
      .div_o  (c_div[i+1]),
      .nb_o   (c_nb[i+1]),
      .quo_o  (c_quo[i+1])
    );
  end

  // Writes land here in item order; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (c_meta[Q_BITS].vld && (c_meta[Q_BITS].cmd == CMD_WRITE) &&
          (c_meta[Q_BITS].idx <= IDX_W'(RATIO_SCALE))) begin
        arctan_mem[c_meta[Q_BITS].idx] <= c_meta[Q_BITS].val;
      end
      t4_r <= arctan_mem[c_quo[Q_BITS]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_r.vld <= 1'b0;
    end else if (adv) begin
      m4_r <= c_meta[Q_BITS];
    end
  end

  always_comb begin
    if (m4_r.zero) begin
      angle = ANG_Q0;
    end else if (m4_r.sub) begin
      angle = m4_r.base - t4_r;
    end else begin
      angle = m4_r.base + t4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m4_r.vld && (m4_r.cmd == CMD_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= -angle;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_heading = heading_r;

endmodule

/* rtl/oata_chk.sv */
// Port-level checker for the octant arctangent core, bound to the top level.
// Depends on oata_pkg and the assertion macro header.
`include "octant_atan2_table_angle_core_assert.svh"

module oata_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [oata_pkg::ANG_W-1:0] out_heading
);
  import oata_pkg::*;

  `OATA_CHK_RST(a_no_result_after_reset, !rst_n |=> !out_valid)
  `OATA_CHK(a_held_result, out_valid && !out_ready |=> out_valid && $stable(out_heading))
  `OATA_CHK(a_ready_when_empty, !out_valid |-> in_ready)
  `OATA_CHK(a_stall_backs_up, out_valid && !out_ready |-> !in_ready)

endmodule

bind octant_atan2_table_angle_core oata_chk u_oata_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_heading (out_heading)
);
